// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define I2P_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define I2P_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/i2p_pkg.sv =====
// Package for the infix to prefix converter: character codes, status codes
// and character class helpers. No dependencies.
`default_nettype none

package i2p_pkg;

  localparam int I2P_MAX_LEN_DEF = 64;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PAREN = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  typedef logic [7:0] char_t;

  function automatic logic is_alnum(input char_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_op(input char_t c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
  endfunction

  function automatic logic [1:0] op_rank(input char_t c);
    logic [1:0] r;
    r = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) r = 2'd1;
    if (c == CH_STAR || c == CH_SLASH) r = 2'd2;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/infix_to_prefix_converter.sv =====
// Infix to prefix converter. Characters load at one per cycle into the
// expression RAM (in_stall stays low while loading). After the last one and
// a start step the block scans the expression right to left, reading one
// character at a time; each operator popped adds the pop and, while entries
// remain, a refill read of the new stack top from RAM, and each ')'
// discarded adds a drop; a finish step follows. The prefix result then
// streams out one character at a time, each read from the shared
// stack/result RAM and registered before the next is read; errors and empty
// results are one transfer each. Operator stack grows up from entry 0 and
// the collected output grows down from entry MAX_LEN-1 of the same RAM; they
// never meet. Input is stalled from the last character until the final
// result is registered for output.
`default_nettype none

module infix_to_prefix_converter
  import i2p_pkg::*;
#(
  parameter int MAX_LEN = I2P_MAX_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] out_char,
  output logic            out_has_char,
  output logic            out_last,
  output logic      [1:0] out_status
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_CHR   = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_ERD   = 3'd5;
  localparam logic [2:0] S_EWR   = 3'd6;
  localparam logic [2:0] S_SOLO  = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          long_r, long_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] depth_r, depth_nxt;
  logic [CW-1:0] n_r, n_nxt;
  char_t         top_r, top_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [1:0]    solo_st_r, solo_st_nxt;

  logic          out_valid_r;
  char_t         out_char_r;
  logic          out_has_r, out_last_r;
  logic [1:0]    out_status_r;

  logic          ex_we, ex_re;
  logic [AW-1:0] ex_waddr, ex_raddr;
  char_t         ex_rdata;
  logic          sk_we, sk_re;
  logic [AW-1:0] sk_waddr, sk_raddr;
  char_t         sk_wdata, sk_rdata;

  logic          out_free, out_load;
  char_t         out_char_nxt;
  logic          out_has_nxt, out_last_nxt;
  logic [1:0]    out_status_nxt;

  logic          do_adv, do_pop, do_drop;
  logic [CW-1:0] i_dec;
  logic [AW-1:0] res_addr;
  char_t         x;

  i2p_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_expr_ram (
    .clk     (clk),
    .wr_en   (ex_we),
    .wr_addr (ex_waddr),
    .wr_data (in_char),
    .rd_en   (ex_re),
    .rd_addr (ex_raddr),
    .rd_data (ex_rdata)
  );

  i2p_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_stack_ram (
    .clk     (clk),
    .wr_en   (sk_we),
    .wr_addr (sk_waddr),
    .wr_data (sk_wdata),
    .rd_en   (sk_re),
    .rd_addr (sk_raddr),
    .rd_data (sk_rdata)
  );

  assign in_stall = (state_r != S_LOAD);
  assign out_free = !out_valid_r || !out_stall;
  assign x        = ex_rdata;
  assign i_dec    = i_r - CW'(1);
  assign res_addr = AW'(CW'(MAX_LEN - 1) - n_r);

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    long_nxt       = long_r;
    i_nxt          = i_r;
    depth_nxt      = depth_r;
    n_nxt          = n_r;
    top_nxt        = top_r;
    ptr_nxt        = ptr_r;
    solo_st_nxt    = solo_st_r;
    ex_we          = 1'b0;
    ex_waddr       = len_r[AW-1:0];
    ex_re          = 1'b0;
    ex_raddr       = AW'(i_dec);
    sk_we          = 1'b0;
    sk_waddr       = res_addr;
    sk_wdata       = x;
    sk_re          = 1'b0;
    sk_raddr       = AW'(depth_r - CW'(2));
    out_load       = 1'b0;
    out_char_nxt   = 8'h00;
    out_has_nxt    = 1'b0;
    out_last_nxt   = 1'b1;
    out_status_nxt = solo_st_r;
    do_adv         = 1'b0;
    do_pop         = 1'b0;
    do_drop        = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (len_r < CW'(MAX_LEN)) begin
            ex_we   = 1'b1;
            len_nxt = len_r + CW'(1);
          end else begin
            long_nxt = 1'b1;
          end
          if (in_last) begin
            depth_nxt = '0;
            n_nxt     = '0;
            if (long_r || len_r == CW'(MAX_LEN)) begin
              solo_st_nxt = ST_LONG;
              len_nxt     = '0;
              long_nxt    = 1'b0;
              state_nxt   = S_SOLO;
            end else begin
              i_nxt     = len_r + CW'(1);
              state_nxt = S_START;
            end
          end
        end
      end

      S_START: begin
        // separate cycle so the read never races the last write
        ex_re     = 1'b1;
        state_nxt = S_CHR;
      end

      S_CHR: begin
        if (is_alnum(x)) begin
          sk_we  = 1'b1;
          n_nxt  = n_r + CW'(1);
          do_adv = 1'b1;
        end else if (is_op(x)) begin
          if (depth_r != '0 && op_rank(top_r) > op_rank(x)) begin
            do_pop = 1'b1;
          end else begin
            sk_we     = 1'b1;
            sk_waddr  = AW'(depth_r);
            top_nxt   = x;
            depth_nxt = depth_r + CW'(1);
            do_adv    = 1'b1;
          end
        end else if (x == CH_RPAREN) begin
          sk_we     = 1'b1;
          sk_waddr  = AW'(depth_r);
          top_nxt   = x;
          depth_nxt = depth_r + CW'(1);
          do_adv    = 1'b1;
        end else if (x == CH_LPAREN) begin
          if (depth_r != '0 && top_r != CH_RPAREN) begin
            do_pop = 1'b1;
          end else if (depth_r != '0) begin
            do_drop = 1'b1;
            do_adv  = 1'b1;
          end else begin
            do_adv = 1'b1;
          end
        end else begin
          do_adv = 1'b1;
        end
      end

      S_FILL: begin
        top_nxt   = sk_rdata;
        state_nxt = (i_r == '0) ? S_FLUSH : S_CHR;
      end

      S_FLUSH: begin
        if (depth_r == '0) begin
          len_nxt  = '0;
          long_nxt = 1'b0;
          if (n_r == '0) begin
            solo_st_nxt = ST_OK;
            state_nxt   = S_SOLO;
          end else begin
            ptr_nxt   = AW'(CW'(MAX_LEN) - n_r);
            state_nxt = S_ERD;
          end
        end else if (top_r == CH_RPAREN) begin
          len_nxt     = '0;
          long_nxt    = 1'b0;
          solo_st_nxt = ST_PAREN;
          state_nxt   = S_SOLO;
        end else begin
          do_pop = 1'b1;
        end
      end

      S_ERD: begin
        sk_re     = 1'b1;
        sk_raddr  = ptr_r;
        state_nxt = S_EWR;
      end

      S_EWR: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_char_nxt   = sk_rdata;
          out_has_nxt    = 1'b1;
          out_last_nxt   = (ptr_r == AW'(MAX_LEN - 1));
          out_status_nxt = ST_OK;
          if (ptr_r == AW'(MAX_LEN - 1)) begin
            state_nxt = S_LOAD;
          end else begin
            ptr_nxt   = ptr_r + AW'(1);
            state_nxt = S_ERD;
          end
        end
      end

      S_SOLO: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_LOAD;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // move to the next character to the left
    if (do_adv) begin
      i_nxt = i_dec;
      if (i_dec != '0) begin
        ex_re     = 1'b1;
        ex_raddr  = AW'(i_dec - CW'(1));
        state_nxt = S_CHR;
      end else begin
        state_nxt = S_FLUSH;
      end
    end

    // pop the top, to the output or discarded; refill top from RAM if entries remain
    if (do_pop || do_drop) begin
      if (do_pop) begin
        sk_we    = 1'b1;
        sk_waddr = res_addr;
        sk_wdata = top_r;
        n_nxt    = n_r + CW'(1);
      end
      depth_nxt = depth_r - CW'(1);
      if (depth_r >= CW'(2)) begin
        sk_re     = 1'b1;
        state_nxt = S_FILL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      len_r       <= '0;
      long_r      <= 1'b0;
      i_r         <= '0;
      depth_r     <= '0;
      n_r         <= '0;
      ptr_r       <= '0;
      solo_st_r   <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      len_r     <= len_nxt;
      long_r    <= long_nxt;
      i_r       <= i_nxt;
      depth_r   <= depth_nxt;
      n_r       <= n_nxt;
      ptr_r     <= ptr_nxt;
      solo_st_r <= solo_st_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (out_load) begin
      out_char_r   <= out_char_nxt;
      out_has_r    <= out_has_nxt;
      out_last_r   <= out_last_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_has_char = out_has_r;
  assign out_last     = out_last_r;
  assign out_status   = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/core/i2p_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds until the next read. No dependencies.
`default_nettype none

module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/i2p_checker.sv =====
// Port-level checker for the infix to prefix converter, bound to the top.
// Depends on assert_macros.svh and i2p_pkg.
`default_nettype none

`include "assert_macros.svh"

module i2p_checker
  import i2p_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_char,
  input wire logic       out_has_char,
  input wire logic       out_last,
  input wire logic [1:0] out_status
);

  `I2P_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_char) && $stable(out_last), "stalled result changed")
  `I2P_ASSERT(a_empty_is_last, out_valid && !out_has_char, out_last && out_char == 8'h00, "charless result must be final and zero")
  `I2P_ASSERT(a_err_no_char, out_valid && out_status != ST_OK, !out_has_char, "error result carries a character")
  `I2P_ASSERT_NEXT(a_load_no_stall, in_valid && !in_stall && !in_last, !in_stall, "stalled after a non-final transfer")

endmodule

bind infix_to_prefix_converter i2p_checker u_i2p_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_last      (in_last),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_char     (out_char),
  .out_has_char (out_has_char),
  .out_last     (out_last),
  .out_status   (out_status)
);

`default_nettype wire

// ===== verif/tb_infix_to_prefix_converter.sv =====
// Self-checking testbench for infix_to_prefix_converter: directed table, long and
// over-length expressions, then random well-formed, broken and noise expressions.
// Depends on i2p_pkg and the converter RTL only.
`default_nettype none

module tb_infix_to_prefix_converter;
  timeunit 1ns;
  timeprecision 1ps;

  import i2p_pkg::*;

  localparam int EXPR_MAX    = I2P_MAX_LEN_DEF;
  localparam int ITEM_TARGET = 430;
  localparam int STUCK_LIMIT = 2000;
  localparam int TAIL_CYCLES = 250;

  typedef struct packed {
    char_t      ch;
    logic       has;
    logic       last;
    logic [1:0] status;
  } prefix_res_t;

  typedef struct packed {
    char_t       ch;
    logic        last;
    logic        typed;
    prefix_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_char = 8'h00;
  logic in_last = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [7:0] out_char;
  logic out_has_char;
  logic out_last;
  logic [1:0] out_status;

  infix_to_prefix_converter u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char      (in_char),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_has_char (out_has_char),
    .out_last     (out_last),
    .out_status   (out_status)
  );

  always #5 clk = ~clk;

  // Predictor state: mirrors the block's expression buffer.
  char_t expr_mem [EXPR_MAX];
  int    expr_len = 0;
  bit    too_long = 1'b0;

  prefix_res_t prefix_expect_q[$];
  prefix_res_t conv_out_q[$];
  dir_row_t    dir_rows[$];
  char_t       expr_q[$];

  bit quiet = 1'b0;
  int n_sent = 0;
  int n_exprs = 0;
  int n_results = 0;
  int n_err_paren = 0;
  int n_err_long = 0;
  int n_errors = 0;
  int stuck_cycles = 0;

  function automatic prefix_res_t mk_res(input char_t ch, input logic has, input logic last,
                                         input logic [1:0] status);
    prefix_res_t r;
    r.ch = ch;
    r.has = has;
    r.last = last;
    r.status = status;
    return r;
  endfunction

  function automatic int prec(input char_t c);
    if (c == CH_STAR || c == CH_SLASH) return 2;
    if (c == CH_PLUS || c == CH_MINUS) return 1;
    return 0;
  endfunction

  // Loads one character; on the final one converts the whole buffer into conv_out_q.
  function automatic void convert_char(input char_t c, input bit last);
    char_t opstk [EXPR_MAX];
    char_t outbuf [EXPR_MAX];
    int sp;
    int n;
    int k;
    char_t x;
    if (expr_len < EXPR_MAX) begin
      expr_mem[expr_len] = c;
      expr_len++;
    end else begin
      too_long = 1'b1;
    end
    if (!last) return;
    n_exprs++;
    if (too_long) begin
      conv_out_q.push_back(mk_res(8'h00, 1'b0, 1'b1, ST_LONG));
      n_err_long++;
      expr_len = 0;
      too_long = 1'b0;
      return;
    end
    sp = 0;
    n = 0;
    for (k = expr_len - 1; k >= 0; k--) begin
      x = expr_mem[k];
      if ((x >= "0" && x <= "9") || (x >= "A" && x <= "Z") || (x >= "a" && x <= "z")) begin
        outbuf[n] = x;
        n++;
      end else if (x == CH_PLUS || x == CH_MINUS || x == CH_STAR || x == CH_SLASH) begin
        while (sp > 0 && prec(opstk[sp-1]) > prec(x)) begin
          outbuf[n] = opstk[sp-1];
          n++;
          sp--;
        end
        opstk[sp] = x;
        sp++;
      end else if (x == CH_RPAREN) begin
        opstk[sp] = x;
        sp++;
      end else if (x == CH_LPAREN) begin
        while (sp > 0 && opstk[sp-1] != CH_RPAREN) begin
          outbuf[n] = opstk[sp-1];
          n++;
          sp--;
        end
        if (sp > 0) sp--;
      end
    end
    expr_len = 0;
    too_long = 1'b0;
    while (sp > 0) begin
      if (opstk[sp-1] == CH_RPAREN) begin
        conv_out_q.push_back(mk_res(8'h00, 1'b0, 1'b1, ST_PAREN));
        n_err_paren++;
        return;
      end
      outbuf[n] = opstk[sp-1];
      n++;
      sp--;
    end
    if (n == 0) begin
      conv_out_q.push_back(mk_res(8'h00, 1'b0, 1'b1, ST_OK));
    end else begin
      for (k = 0; k < n; k++)
        conv_out_q.push_back(mk_res(outbuf[n-1-k], 1'b1, k == n - 1, ST_OK));
    end
  endfunction

  function automatic void add_row(input char_t ch, input bit last, input bit typed,
                                  input prefix_res_t res);
    dir_row_t r;
    r.ch = ch;
    r.last = last;
    r.typed = typed;
    r.res = res;
    dir_rows.push_back(r);
  endfunction

  function automatic char_t rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'h30 + 8'($urandom_range(0, 9));
      1:       return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic char_t rand_op();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic void gen_term(input int depth);
    if (depth > 0 && $urandom_range(0, 3) == 0) begin
      expr_q.push_back(CH_LPAREN);
      gen_expr(depth - 1);
      expr_q.push_back(CH_RPAREN);
    end else begin
      expr_q.push_back(rand_operand());
    end
    if ($urandom_range(0, 15) == 0) expr_q.push_back(" ");
  endfunction

  function automatic void gen_expr(input int depth);
    int terms;
    int t;
    terms = $urandom_range(1, 3);
    gen_term(depth);
    for (t = 1; t < terms; t++) begin
      expr_q.push_back(rand_op());
      gen_term(depth);
    end
  endfunction

  // Corrupts one spot of a well-formed expression.
  function automatic void break_expr();
    int pos;
    pos = $urandom_range(0, expr_q.size() - 1);
    case ($urandom_range(0, 4))
      0: expr_q[pos] = $urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN;
      1: expr_q[pos] = 8'($urandom_range(0, 255));
      2: if (expr_q.size() > 1) expr_q.delete(pos);
      3: expr_q.push_front(CH_LPAREN);
      default: expr_q.push_back(CH_RPAREN);
    endcase
  endfunction

  task automatic send_char(input char_t c, input bit last, input bit typed,
                           input prefix_res_t typed_res);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    in_last  <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    n_sent++;
    conv_out_q.delete();
    convert_char(c, last);
    if (typed) begin
      prefix_expect_q.push_back(typed_res);
    end else begin
      foreach (conv_out_q[i]) prefix_expect_q.push_back(conv_out_q[i]);
    end
  endtask

  task automatic send_expr();
    int i;
    for (i = 0; i < expr_q.size(); i++)
      send_char(expr_q[i], i == expr_q.size() - 1, 1'b0, '0);
  endtask

  always @(posedge clk) out_stall <= !quiet && ($urandom_range(0, 99) < 10);

  function automatic void report(input string what, input prefix_res_t want,
                                 input prefix_res_t got);
    n_errors++;
    if (n_errors <= 10)
      $display({"ERROR %s: expected ch=%02h has=%0d last=%0d st=%0d, ",
                "got ch=%02h has=%0d last=%0d st=%0d"},
               what, want.ch, want.has, want.last, want.status,
               got.ch, got.has, got.last, got.status);
  endfunction

  prefix_res_t got_res;
  prefix_res_t want_res;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      n_results++;
      got_res = mk_res(out_char, out_has_char, out_last, out_status);
      if (prefix_expect_q.size() == 0) begin
        report("unexpected transfer", '0, got_res);
      end else begin
        want_res = prefix_expect_q.pop_front();
        if (got_res.ch !== want_res.ch || got_res.has !== want_res.has ||
            got_res.last !== want_res.last || got_res.status !== want_res.status)
          report("result mismatch", want_res, got_res);
      end
    end
  end

  // Watchdog: cycles without a transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
      $display("infix_to_prefix_converter test failed");
      $finish;
    end
  end

  initial begin
    int i;
    int pick;
    int len;
    prefix_res_t empty_res;
    empty_res = mk_res(8'h00, 1'b0, 1'b1, ST_OK);

    add_row("A", 1, 1, mk_res("A", 1'b1, 1'b1, ST_OK));
    add_row(CH_LPAREN, 1, 1, empty_res);
    add_row(CH_RPAREN, 1, 1, mk_res(8'h00, 1'b0, 1'b1, ST_PAREN));
    add_row(8'h00, 1, 1, empty_res);
    add_row(8'hFF, 1, 1, empty_res);
    // leftover ')'
    add_row("a", 0, 0, '0);
    add_row(CH_PLUS, 0, 0, '0);
    add_row("b", 0, 0, '0);
    add_row(CH_RPAREN, 1, 1, mk_res(8'h00, 1'b0, 1'b1, ST_PAREN));
    // (z-0*9)/Z
    add_row(CH_LPAREN, 0, 0, '0);
    add_row("z", 0, 0, '0);
    add_row(CH_MINUS, 0, 0, '0);
    add_row("0", 0, 0, '0);
    add_row(CH_STAR, 0, 0, '0);
    add_row("9", 0, 0, '0);
    add_row(CH_RPAREN, 0, 0, '0);
    add_row(CH_SLASH, 0, 0, '0);
    add_row("Z", 1, 0, '0);
    // unmatched '('
    add_row(CH_LPAREN, 0, 0, '0);
    add_row("a", 0, 0, '0);
    add_row(CH_PLUS, 0, 0, '0);
    add_row("b", 1, 0, '0);
    // ignored character between operands
    add_row("7", 0, 0, '0);
    add_row("#", 0, 0, '0);
    add_row("x", 1, 0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r])
      send_char(dir_rows[r].ch, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].res);

    // Full buffer with a result per character, then two over-length expressions.
    expr_q.delete();
    for (i = 0; i < EXPR_MAX - 1; i++) expr_q.push_back((i % 2) ? rand_op() : rand_operand());
    expr_q.push_back(rand_operand());
    send_expr();
    expr_q.delete();
    for (i = 0; i < EXPR_MAX + 1; i++) expr_q.push_back((i % 2) ? rand_op() : rand_operand());
    send_expr();
    expr_q.delete();
    for (i = 0; i < EXPR_MAX + 16; i++) expr_q.push_back(8'($urandom_range(0, 255)));
    send_expr();

    while (n_sent < ITEM_TARGET) begin
      quiet = (n_sent >= 260 && n_sent < 360);
      expr_q.delete();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) expr_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        gen_expr(2);
        if (pick < 32) break_expr();
      end
      send_expr();
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (prefix_expect_q.size() != 0) @(posedge clk);
    // idle a while to catch any surplus result transfer
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d characters in %0d expressions, checked %0d result transfers",
             n_sent, n_exprs, n_results);
    $display("error results seen: %0d leftover ')', %0d too long; mismatches: %0d",
             n_err_paren, n_err_long, n_errors);
    if (n_errors == 0)
      $display("infix_to_prefix_converter test passed");
    else
      $display("infix_to_prefix_converter test failed");
    $finish;
  end

endmodule

`default_nettype wire
